// File: src/wra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wra_pkg: shared types and constants of the window rank/average filter
// Mode and register codes, the job word passed from front to back end,
// and the back-end state encoding.
// ----------------------------------------------------------------------------
package wra_pkg;

    localparam int MAX_ROWS_DEF = 8;
    localparam int MAX_COLS_DEF = 8;
    localparam int PIX_W        = 8;
    localparam int NUM_CH       = 3;
    // wide enough for a 32 by 32 window
    localparam int JOB_N_W      = 11;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 4;

    typedef enum logic [1:0] {
        MODE_MEDIAN  = 2'd0,
        MODE_AVERAGE = 2'd1,
        MODE_MIN     = 2'd2,
        MODE_MAX     = 2'd3
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE = 2'd0,
        CFG_ROWS = 2'd1,
        CFG_COLS = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [JOB_N_W-1:0] n;
        mode_t              mode;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EVAL,
        BK_DIV,
        BK_EMIT
    } back_state_t;

endpackage

// File: src/window_rank_average_rgb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_rank_average_rgb_top: windowed median/mean/min/max filter, RGB
// Collects one window of pixels and emits one filtered pixel per window.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one window pixel per word, row-major. m_ channel: one pixel
//   per completed window. cfg_we/cfg_addr/cfg_wdata write mode (0), rows
//   (1) and cols (2); write them only while the block is idle.
//   Pixels of a window are taken one per cycle. After the last one the
//   input stalls while the reduction engine scans the store, n = rows*cols:
//     min/max:  one scan of the store, then the result
//     mean:     one scan for the sums, then one serial divider step per sum bit
//     median:   one scan per result bit for each rank, two ranks for even n
//   The scan length is set by the single read port of the window store.
//   The result sits in an output register; a stalled receiver does not
//   block the next window's pixels, only the next result.
//   Reset clears the pixel count, the job queue and the output valid, and
//   sets mode median with a 3 by 3 window. The store needs no clearing.
// ----------------------------------------------------------------------------
module window_rank_average_rgb_top #(
    parameter int MAX_ROWS = wra_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = wra_pkg::MAX_COLS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // pixel_blue, pixel_green, pixel_red
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // out_blue, out_green, out_red
    input  logic                           cfg_we,
    input  logic [wra_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [wra_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    wra_pkg::mode_t mode_reg;
    logic [3:0]     rows_reg, cols_reg;

    logic              job_push, job_pop, job_avail, back_busy;
    wra_pkg::job_t     job_in, job_out;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [23:0]       wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= wra_pkg::MODE_MEDIAN;
            rows_reg <= 4'd3;
            cols_reg <= 4'd3;
        end else if (cfg_we) begin
            if (cfg_addr == wra_pkg::CFG_MODE) begin
                mode_reg <= wra_pkg::mode_t'(cfg_wdata[1:0]);
            end
            if (cfg_addr == wra_pkg::CFG_ROWS) begin
                rows_reg <= cfg_wdata;
            end
            if (cfg_addr == wra_pkg::CFG_COLS) begin
                cols_reg <= cfg_wdata;
            end
        end
    end

    wra_front #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .mode       (mode_reg),
        .window_rows(rows_reg),
        .window_cols(cols_reg),
        .stall      (job_avail || back_busy),
        .job_push   (job_push),
        .job        (job_in),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    wra_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_data(job_in),
        .pop      (job_pop),
        .pop_data (job_out),
        .not_empty(job_avail)
    );

    wra_back #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .job_valid(job_avail),
        .job      (job_out),
        .job_pop  (job_pop),
        .busy     (back_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: src/wra_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wra_front: pixel intake
// Writes each accepted pixel into the window store, tracks the pixel count
// and posts a job once the window is complete.
// ----------------------------------------------------------------------------
module wra_front #(
    parameter int MAX_ROWS = wra_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = wra_pkg::MAX_COLS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [23:0]             s_tdata,
    input  wra_pkg::mode_t          mode,
    input  logic [3:0]              window_rows,
    input  logic [3:0]              window_cols,
    input  logic                    stall,
    output logic                    job_push,
    output wra_pkg::job_t           job,
    output logic                    wr_en,
    output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] wr_addr,
    output logic [23:0]             wr_data
);
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rows_x, cols_x, n_win, idx, count_inc;
    logic             accept;

    always_comb begin
        if (window_rows == 4'd0) begin
            rows_x = CNT_W'(1);
        end else if (int'(window_rows) > MAX_ROWS) begin
            rows_x = CNT_W'(MAX_ROWS);
        end else begin
            rows_x = CNT_W'(window_rows);
        end
        if (window_cols == 4'd0) begin
            cols_x = CNT_W'(1);
        end else if (int'(window_cols) > MAX_COLS) begin
            cols_x = CNT_W'(MAX_COLS);
        end else begin
            cols_x = CNT_W'(window_cols);
        end
        n_win = rows_x * cols_x;
    end

    assign s_tready = !stall;
    assign accept   = s_tvalid && s_tready;

    // a full store keeps overwriting its last entry
    assign idx       = (count_reg >= CNT_W'(DEPTH)) ? CNT_W'(DEPTH - 1) : count_reg;
    assign count_inc = (count_reg < CNT_W'(DEPTH)) ? count_reg + CNT_W'(1) : count_reg;

    assign wr_en    = accept;
    assign wr_addr  = ADDR_W'(idx);
    assign wr_data  = s_tdata;
    assign job_push = accept && (count_inc >= n_win);
    assign job.n    = wra_pkg::JOB_N_W'(n_win);
    assign job.mode = mode;

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            count_next = job_push ? '0 : count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// File: src/wra_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wra_queue: two-entry job queue
// Decouples the pixel intake from the reduction engine.
// ----------------------------------------------------------------------------
module wra_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  wra_pkg::job_t push_data,
    input  logic          pop,
    output wra_pkg::job_t pop_data,
    output logic          not_empty
);
    wra_pkg::job_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;

    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/wra_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wra_back: window store and reduction engine
// Holds the window store, scans it once per pass for all three channels
// (radix select for the median, sum plus serial divide for the mean,
// running min/max) and drives the output register.
// ----------------------------------------------------------------------------
module wra_back #(
    parameter int MAX_ROWS = wra_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = wra_pkg::MAX_COLS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_en,
    input  logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] wr_addr,
    input  logic [23:0]             wr_data,
    input  logic                    job_valid,
    input  wra_pkg::job_t           job,
    output logic                    job_pop,
    output logic                    busy,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata
);
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = CNT_W + wra_pkg::PIX_W;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int NCH    = wra_pkg::NUM_CH;

    logic [23:0] mem [DEPTH];
    logic [23:0] rd_word_reg;

    wra_pkg::back_state_t state_reg, state_next;
    wra_pkg::mode_t       mode_reg, mode_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 rd_vld_reg, rd_en;
    logic                 second_reg, second_next;
    logic [7:0]           mask_reg, mask_next;
    logic [7:0]           bsel_reg, bsel_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic [23:0]          out_reg, out_next;

    logic [7:0]       prefix_reg [NCH], prefix_next [NCH];
    logic [CNT_W-1:0] k_reg      [NCH], k_next      [NCH];
    logic [CNT_W-1:0] cnt_reg    [NCH], cnt_next    [NCH];
    logic [SUM_W-1:0] sum_reg    [NCH], sum_next    [NCH];
    logic [7:0]       min_reg    [NCH], min_next    [NCH];
    logic [7:0]       max_reg    [NCH], max_next    [NCH];
    logic [7:0]       first_reg  [NCH], first_next  [NCH];
    logic [7:0]       res_reg    [NCH], res_next    [NCH];
    logic [SUM_W-1:0] quot_reg   [NCH], quot_next   [NCH];
    logic [CNT_W-1:0] rem_reg    [NCH], rem_next    [NCH];
    logic             clr_acc;

    assign busy     = (state_reg != wra_pkg::BK_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        logic [7:0]     v;
        logic [7:0]     pv;
        logic [CNT_W:0] r2;
        logic           qb;

        v              = 8'h00;
        pv             = 8'h00;
        r2             = '0;
        qb             = 1'b0;
        state_next     = state_reg;
        mode_next      = mode_reg;
        n_next         = n_reg;
        issue_next     = issue_reg;
        second_next    = second_reg;
        mask_next      = mask_reg;
        bsel_next      = bsel_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        prefix_next    = prefix_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        first_next     = first_reg;
        res_next       = res_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        clr_acc        = 1'b0;
        rd_en          = 1'b0;
        job_pop        = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            wra_pkg::BK_IDLE: begin
                if (job_valid) begin
                    job_pop     = 1'b1;
                    n_next      = CNT_W'(job.n);
                    mode_next   = job.mode;
                    issue_next  = '0;
                    second_next = 1'b0;
                    mask_next   = 8'h00;
                    bsel_next   = 8'h80;
                    clr_acc     = 1'b1;
                    for (int c = 0; c < NCH; c++) begin
                        prefix_next[c] = 8'h00;
                        k_next[c]      = (CNT_W'(job.n) - CNT_W'(1)) >> 1;
                    end
                    state_next = wra_pkg::BK_SCAN;
                end
            end
            wra_pkg::BK_SCAN: begin
                if (issue_reg < n_reg) begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + CNT_W'(1);
                end else if (!rd_vld_reg) begin
                    state_next = wra_pkg::BK_EVAL;
                end
                if (rd_vld_reg) begin
                    for (int c = 0; c < NCH; c++) begin
                        v           = rd_word_reg[8*c +: 8];
                        sum_next[c] = sum_reg[c] + SUM_W'(v);
                        if (v < min_reg[c]) begin
                            min_next[c] = v;
                        end
                        if (v > max_reg[c]) begin
                            max_next[c] = v;
                        end
                        if ((((v ^ prefix_reg[c]) & mask_reg) == 8'h00)
                                && ((v & bsel_reg) == 8'h00)) begin
                            cnt_next[c] = cnt_reg[c] + CNT_W'(1);
                        end
                    end
                end
            end
            wra_pkg::BK_EVAL: begin
                unique case (mode_reg)
                    wra_pkg::MODE_MEDIAN: begin
                        issue_next = '0;
                        clr_acc    = 1'b1;
                        state_next = wra_pkg::BK_SCAN;
                        mask_next  = {1'b1, mask_reg[7:1]};
                        bsel_next  = bsel_reg >> 1;
                        for (int c = 0; c < NCH; c++) begin
                            pv = prefix_reg[c];
                            // rank falls in the upper half: set this bit
                            if (k_reg[c] >= cnt_reg[c]) begin
                                pv        = prefix_reg[c] | bsel_reg;
                                k_next[c] = k_reg[c] - cnt_reg[c];
                            end
                            prefix_next[c] = pv;
                            if (bsel_reg[0]) begin
                                if (!second_reg && !n_reg[0]) begin
                                    first_next[c]  = pv;
                                    prefix_next[c] = 8'h00;
                                    k_next[c]      = n_reg >> 1;
                                end else if (second_reg) begin
                                    res_next[c] = 8'(({1'b0, first_reg[c]}
                                                       + {1'b0, pv}) >> 1);
                                end else begin
                                    res_next[c] = pv;
                                end
                            end
                        end
                        if (bsel_reg[0]) begin
                            if (!second_reg && !n_reg[0]) begin
                                second_next = 1'b1;
                                mask_next   = 8'h00;
                                bsel_next   = 8'h80;
                            end else begin
                                clr_acc    = 1'b0;
                                state_next = wra_pkg::BK_EMIT;
                            end
                        end
                    end
                    wra_pkg::MODE_AVERAGE: begin
                        for (int c = 0; c < NCH; c++) begin
                            quot_next[c] = sum_reg[c];
                            rem_next[c]  = '0;
                        end
                        step_next  = '0;
                        state_next = wra_pkg::BK_DIV;
                    end
                    wra_pkg::MODE_MIN: begin
                        res_next   = min_reg;
                        state_next = wra_pkg::BK_EMIT;
                    end
                    wra_pkg::MODE_MAX: begin
                        res_next   = max_reg;
                        state_next = wra_pkg::BK_EMIT;
                    end
                    default: begin
                        state_next = wra_pkg::BK_EMIT;
                    end
                endcase
            end
            wra_pkg::BK_DIV: begin
                // one restoring divide step per cycle on each channel
                for (int c = 0; c < NCH; c++) begin
                    r2 = {rem_reg[c], quot_reg[c][SUM_W-1]};
                    qb = (r2 >= {1'b0, n_reg});
                    if (qb) begin
                        rem_next[c] = CNT_W'(r2 - {1'b0, n_reg});
                    end else begin
                        rem_next[c] = r2[CNT_W-1:0];
                    end
                    quot_next[c] = {quot_reg[c][SUM_W-2:0], qb};
                    res_next[c]  = quot_next[c][7:0];
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = wra_pkg::BK_EMIT;
                end
            end
            wra_pkg::BK_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_next       = {res_reg[2], res_reg[1], res_reg[0]};
                    out_valid_next = 1'b1;
                    state_next     = wra_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = wra_pkg::BK_IDLE;
            end
        endcase

        if (clr_acc) begin
            for (int c = 0; c < NCH; c++) begin
                cnt_next[c] = '0;
                sum_next[c] = '0;
                min_next[c] = 8'hFF;
                max_next[c] = 8'h00;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wra_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        n_reg       <= n_next;
        issue_reg   <= issue_next;
        second_reg  <= second_next;
        mask_reg    <= mask_next;
        bsel_reg    <= bsel_next;
        step_reg    <= step_next;
        out_reg     <= out_next;
        prefix_reg  <= prefix_next;
        k_reg       <= k_next;
        cnt_reg     <= cnt_next;
        sum_reg     <= sum_next;
        min_reg     <= min_next;
        max_reg     <= max_next;
        first_reg   <= first_next;
        res_reg     <= res_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[issue_reg[ADDR_W-1:0]];
        end
    end

endmodule
